@@ rtl/core/prd_pkg.sv @@
package prd_pkg;

	// Fixed field widths
	localparam int CHAN_W     = 8;
	localparam int POS_W      = 20;
	localparam int LEN_W      = 21;
	localparam int FP_W       = 21;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;
	localparam int COLOR_W    = 3 * CHAN_W;
	localparam int PROD_W     = 2 * CHAN_W;
	// Room for any frame limit (parameter range tops out at 2^24)
	localparam int LIM_W      = 25;

	localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;
	localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;

	typedef enum logic [1:0] {
		CMD_PAL_WR = 2'd0,
		CMD_DATA   = 2'd1,
		CMD_FRAME  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_COUNT = 2'd0,
		PH_ALPHA = 2'd1,
		PH_INDEX = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		MODE_RGB  = 2'd0,
		MODE_RGBA = 2'd1,
		MODE_BGRA = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OUT_MODE     = 3'd0,
		CFG_TRANS_RED    = 3'd1,
		CFG_TRANS_GREEN  = 3'd2,
		CFG_TRANS_BLUE   = 3'd3,
		CFG_ALPHA_THRESH = 3'd4,
		CFG_FRAME_PIXELS = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        out_mode;
		logic [CHAN_W-1:0] trans_red;
		logic [CHAN_W-1:0] trans_green;
		logic [CHAN_W-1:0] trans_blue;
		logic [CHAN_W-1:0] alpha_threshold;
		logic [FP_W-1:0]   frame_pixels;
	} cfg_t;

	// One run leaving the parser
	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [LEN_W-1:0]  len;
		logic              err;
		logic              pixel;   // palette pixel, else transparent run
		logic              oob;     // palette index beyond the table
		logic [CHAN_W-1:0] alpha;
	} run_t;

endpackage

@@ rtl/core/prd_if.sv @@
interface prd_byte_if import prd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic [CHAN_W-1:0] pal_index;
	logic [CHAN_W-1:0] pal_red;
	logic [CHAN_W-1:0] pal_green;
	logic [CHAN_W-1:0] pal_blue;
	logic [CHAN_W-1:0] data_byte;

	modport source (
		output valid, cmd, pal_index, pal_red, pal_green, pal_blue, data_byte,
		input  ready
	);
	modport sink (
		input  valid, cmd, pal_index, pal_red, pal_green, pal_blue, data_byte,
		output ready
	);
endinterface

interface prd_run_if import prd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  pixel_pos;
	logic [LEN_W-1:0]  run_len;
	logic [CHAN_W-1:0] chan0;
	logic [CHAN_W-1:0] chan1;
	logic [CHAN_W-1:0] chan2;
	logic [CHAN_W-1:0] chan3;
	logic              overflow_error;

	modport source (
		output valid, pixel_pos, run_len, chan0, chan1, chan2, chan3, overflow_error,
		input  ready
	);
	modport sink (
		input  valid, pixel_pos, run_len, chan0, chan1, chan2, chan3, overflow_error,
		output ready
	);
endinterface

@@ rtl/core/prd_palette.sv @@
module prd_palette import prd_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [COLOR_W-1:0]       wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [COLOR_W-1:0]       rd_data
);

	logic [COLOR_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/prd_parse.sv @@
module prd_parse import prd_pkg::*; #(
	parameter int MAX_FRAME_PIXELS = 1048576,
	parameter int PALETTE_DEPTH    = 256
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	prd_byte_if.sink bytes,
	input  logic   s2_ready,
	output logic   v_s1,
	output run_t   run_s1
);

	localparam int PW    = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int SUM_W = LIM_W + 1;
	localparam int IDX_W = CHAN_W + 1;

	phase_t            phase_q, phase_d;
	logic [CHAN_W-1:0] count_q, count_d;
	logic [CHAN_W-1:0] alpha_q, alpha_d;
	logic [PW-1:0]     pos_q, pos_d;
	logic              accept;
	logic [LIM_W-1:0]  lim;
	logic [CHAN_W-1:0] len_data;
	logic [SUM_W-1:0]  end_sum;
	logic              ovf;
	logic              emit;
	run_t              run_d;
	logic              v_s1_q;
	run_t              run_s1_q;

	// s1 holds one run; it frees up whenever s2 can take it
	assign bytes.ready = !v_s1_q || s2_ready;
	assign accept      = bytes.valid && bytes.ready;

	// Frame limit, clamped to the largest supported frame
	assign lim = (LIM_W'(cfg.frame_pixels) > LIM_W'(MAX_FRAME_PIXELS)) ?
		LIM_W'(MAX_FRAME_PIXELS) : LIM_W'(cfg.frame_pixels);

	// Run end and overflow check
	assign len_data = (phase_q == PH_INDEX) ? CHAN_W'(1) : count_q;
	assign end_sum  = SUM_W'(pos_q) + SUM_W'(len_data);
	assign ovf      = end_sum > SUM_W'(lim);

	// Next parse state
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		alpha_d = alpha_q;
		pos_d   = pos_q;
		case (cmd_t'(bytes.cmd))
			CMD_FRAME: begin
				phase_d = PH_COUNT;
				count_d = '0;
				alpha_d = '0;
				pos_d   = '0;
			end
			CMD_DATA: begin
				case (phase_q)
					PH_COUNT: begin
						count_d = bytes.data_byte;
						phase_d = PH_ALPHA;
					end
					PH_ALPHA: begin
						alpha_d = bytes.data_byte;
						if (bytes.data_byte == CHAN_ZERO) begin
							phase_d = PH_COUNT;
							if (count_q != CHAN_ZERO && !ovf) begin
								pos_d = PW'(end_sum);
							end
						end else if (count_q == CHAN_ZERO) begin
							phase_d = PH_COUNT;
						end else begin
							phase_d = PH_INDEX;
						end
					end
					PH_INDEX: begin
						if (!ovf) begin
							pos_d = PW'(end_sum);
						end
						if (count_q != CHAN_ZERO) begin
							count_d = count_q - CHAN_W'(1);
						end
						if (count_q <= CHAN_W'(1)) begin
							phase_d = PH_COUNT;
						end
					end
					default: begin
						phase_d = PH_COUNT;
					end
				endcase
			end
			default: ;
		endcase
	end

	// Run emitted by this byte
	always_comb begin
		emit          = 1'b0;
		run_d.pos     = POS_W'(pos_q);
		run_d.len     = LEN_W'(len_data);
		run_d.err     = ovf;
		run_d.pixel   = (phase_q == PH_INDEX);
		run_d.oob     = IDX_W'(bytes.data_byte) >= IDX_W'(PALETTE_DEPTH);
		run_d.alpha   = (phase_q == PH_INDEX) ? alpha_q : CHAN_ZERO;
		case (cmd_t'(bytes.cmd))
			CMD_FRAME: begin
				emit        = (lim != '0);
				run_d.pos   = '0;
				run_d.len   = LEN_W'(lim);
				run_d.err   = 1'b0;
				run_d.pixel = 1'b0;
				run_d.alpha = CHAN_ZERO;
			end
			CMD_DATA: begin
				case (phase_q)
					PH_ALPHA: emit = (bytes.data_byte == CHAN_ZERO) && (count_q != CHAN_ZERO);
					PH_INDEX: emit = 1'b1;
					default:  emit = 1'b0;
				endcase
			end
			default: ;
		endcase
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			count_q <= '0;
			alpha_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			count_q <= count_d;
			alpha_q <= alpha_d;
			pos_q   <= pos_d;
		end
	end

	// Stage 1: run descriptor, aligned with the palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (bytes.ready) begin
			v_s1_q <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_s1_q <= run_d;
		end
	end

	assign v_s1   = v_s1_q;
	assign run_s1 = run_s1_q;

endmodule

@@ rtl/core/prd_color.sv @@
module prd_color import prd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               v_s1,
	input  run_t               run_s1,
	input  logic [COLOR_W-1:0] pal_rd,
	output logic               s2_ready,
	prd_run_if.source          runs
);

	// Exact floor(x/255) for x up to 255*255
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] t;
		t = (PROD_W+1)'(x) + (PROD_W+1)'(1) + (PROD_W+1)'(x >> CHAN_W);
		return CHAN_W'(t >> CHAN_W);
	endfunction

	logic              mode_rgb;
	logic [CHAN_W-1:0] pal_r, pal_g, pal_b, inv_a;
	logic              trans_d, blend_d;
	logic [PROD_W-1:0] sum_r_d, sum_g_d, sum_b_d;

	logic               v_s2_q;
	run_t               run_s2;
	logic [COLOR_W-1:0] col_s2;
	logic [PROD_W-1:0]  sum_r_s2, sum_g_s2, sum_b_s2;
	logic               trans_s2, blend_s2;

	logic              adv_out;
	logic [CHAN_W-1:0] fin_r, fin_g, fin_b, fin_a;
	logic [CHAN_W-1:0] c0_d, c1_d, c2_d, c3_d;

	logic              out_v_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [CHAN_W-1:0] out_c0_q, out_c1_q, out_c2_q, out_c3_q;
	logic              out_err_q;

	assign mode_rgb = (cfg.out_mode == MODE_RGB);
	assign adv_out  = !out_v_q || runs.ready;
	assign s2_ready = !v_s2_q || adv_out;

	// s1: palette color and blend products
	assign pal_r = run_s1.oob ? CHAN_ZERO : pal_rd[3*CHAN_W-1:2*CHAN_W];
	assign pal_g = run_s1.oob ? CHAN_ZERO : pal_rd[2*CHAN_W-1:CHAN_W];
	assign pal_b = run_s1.oob ? CHAN_ZERO : pal_rd[CHAN_W-1:0];
	assign inv_a = CHAN_MAX - run_s1.alpha;

	assign trans_d = !run_s1.pixel || (mode_rgb && run_s1.alpha < cfg.alpha_threshold);
	assign blend_d = mode_rgb;

	assign sum_r_d = PROD_W'(pal_r) * PROD_W'(run_s1.alpha)
		+ PROD_W'(cfg.trans_red) * PROD_W'(inv_a);
	assign sum_g_d = PROD_W'(pal_g) * PROD_W'(run_s1.alpha)
		+ PROD_W'(cfg.trans_green) * PROD_W'(inv_a);
	assign sum_b_d = PROD_W'(pal_b) * PROD_W'(run_s1.alpha)
		+ PROD_W'(cfg.trans_blue) * PROD_W'(inv_a);

	// Stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_q <= 1'b0;
		end else if (s2_ready) begin
			v_s2_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && v_s1) begin
			run_s2   <= run_s1;
			col_s2   <= {pal_r, pal_g, pal_b};
			sum_r_s2 <= sum_r_d;
			sum_g_s2 <= sum_g_d;
			sum_b_s2 <= sum_b_d;
			trans_s2 <= trans_d;
			blend_s2 <= blend_d;
		end
	end

	// s2: final color
	always_comb begin
		if (trans_s2) begin
			fin_r = cfg.trans_red;
			fin_g = cfg.trans_green;
			fin_b = cfg.trans_blue;
		end else if (blend_s2) begin
			fin_r = div255(sum_r_s2);
			fin_g = div255(sum_g_s2);
			fin_b = div255(sum_b_s2);
		end else begin
			fin_r = col_s2[3*CHAN_W-1:2*CHAN_W];
			fin_g = col_s2[2*CHAN_W-1:CHAN_W];
			fin_b = col_s2[CHAN_W-1:0];
		end
		fin_a = run_s2.alpha;
	end

	// Channel order; an overflowed run carries no color
	always_comb begin
		c1_d = fin_g;
		case (mode_t'(cfg.out_mode))
			MODE_RGB: begin
				c0_d = fin_r;
				c2_d = fin_b;
				c3_d = CHAN_ZERO;
			end
			MODE_RGBA: begin
				c0_d = fin_r;
				c2_d = fin_b;
				c3_d = fin_a;
			end
			default: begin
				c0_d = fin_b;
				c2_d = fin_r;
				c3_d = fin_a;
			end
		endcase
		if (run_s2.err) begin
			c0_d = CHAN_ZERO;
			c1_d = CHAN_ZERO;
			c2_d = CHAN_ZERO;
			c3_d = CHAN_ZERO;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_out) begin
			out_v_q <= v_s2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s2_q) begin
			out_pos_q <= run_s2.pos;
			out_len_q <= run_s2.len;
			out_c0_q  <= c0_d;
			out_c1_q  <= c1_d;
			out_c2_q  <= c2_d;
			out_c3_q  <= c3_d;
			out_err_q <= run_s2.err;
		end
	end

	assign runs.valid          = out_v_q;
	assign runs.pixel_pos      = out_pos_q;
	assign runs.run_len        = out_len_q;
	assign runs.chan0          = out_c0_q;
	assign runs.chan1          = out_c1_q;
	assign runs.chan2          = out_c2_q;
	assign runs.chan3          = out_c3_q;
	assign runs.overflow_error = out_err_q;

endmodule

@@ rtl/core/palette_rle_sprite_decoder.sv @@
// Palette-indexed run-length sprite decoder.
// bytes (sink): one item per transfer. cmd selects a palette entry write,
//   an encoded data byte (count, alpha or palette index) or a frame start.
// runs (source): one run per transfer: first pixel, length, four channels
//   in the order set by out_mode, and an overflow flag for a suppressed run.
// cfg_wr_en/cfg_index/cfg_data: register writes, only while no byte is in
//   flight.
// Throughput: one byte per cycle while bytes.ready is high; the parser and
//   the single palette read per byte both finish in the transfer cycle.
// Pipeline: the palette read lands in stage 1, where the blend products are
//   formed; stage 2 picks the final color, dividing by 255 when blending,
//   and feeds the output register. Bytes that cause no run leave nothing
//   behind.
// Reset: registers return to their defaults (BGRA, black transparent
//   color, threshold 1, frame size 0) and the parser expects a count byte.
//   Palette contents are undefined until written; no clearing pass runs.
// Stall: when runs is not taken, the output register, stage 2 and stage 1
//   hold in turn; bytes.ready drops only once all three are full.
module palette_rle_sprite_decoder import prd_pkg::*; #(
	parameter int MAX_FRAME_PIXELS = 1048576,
	parameter int PALETTE_DEPTH    = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	prd_byte_if.sink              bytes,
	prd_run_if.source             runs
);

	localparam int AW    = $clog2(PALETTE_DEPTH);
	localparam int IDX_W = CHAN_W + 1;

	cfg_t               cfg_q;
	logic               byte_xfer;
	logic               pal_wr_en;
	logic [COLOR_W-1:0] pal_rd;
	logic               v_s1;
	run_t               run_s1;
	logic               s2_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_mode        <= MODE_BGRA;
			cfg_q.trans_red       <= '0;
			cfg_q.trans_green     <= '0;
			cfg_q.trans_blue      <= '0;
			cfg_q.alpha_threshold <= CHAN_W'(1);
			cfg_q.frame_pixels    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OUT_MODE:     cfg_q.out_mode        <= cfg_data[1:0];
				CFG_TRANS_RED:    cfg_q.trans_red       <= cfg_data[CHAN_W-1:0];
				CFG_TRANS_GREEN:  cfg_q.trans_green     <= cfg_data[CHAN_W-1:0];
				CFG_TRANS_BLUE:   cfg_q.trans_blue      <= cfg_data[CHAN_W-1:0];
				CFG_ALPHA_THRESH: cfg_q.alpha_threshold <= cfg_data[CHAN_W-1:0];
				CFG_FRAME_PIXELS: cfg_q.frame_pixels    <= cfg_data[FP_W-1:0];
				default: ;
			endcase
		end
	end

	// Palette write on an in-range palette item
	assign byte_xfer = bytes.valid && bytes.ready;
	assign pal_wr_en = byte_xfer && (bytes.cmd == CMD_PAL_WR)
		&& (IDX_W'(bytes.pal_index) < IDX_W'(PALETTE_DEPTH));

	prd_palette #(
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk     (clk),
		.wr_en   (pal_wr_en),
		.wr_addr (bytes.pal_index[AW-1:0]),
		.wr_data ({bytes.pal_red, bytes.pal_green, bytes.pal_blue}),
		.rd_en   (byte_xfer),
		.rd_addr (bytes.data_byte[AW-1:0]),
		.rd_data (pal_rd)
	);

	prd_parse #(
		.MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
		.PALETTE_DEPTH    (PALETTE_DEPTH)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.bytes    (bytes),
		.s2_ready (s2_ready),
		.v_s1     (v_s1),
		.run_s1   (run_s1)
	);

	prd_color u_color (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.v_s1     (v_s1),
		.run_s1   (run_s1),
		.pal_rd   (pal_rd),
		.s2_ready (s2_ready),
		.runs     (runs)
	);

	// A suppressed run carries no color
	a_err_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		runs.valid && runs.overflow_error |->
			runs.chan0 == CHAN_ZERO && runs.chan1 == CHAN_ZERO &&
			runs.chan2 == CHAN_ZERO && runs.chan3 == CHAN_ZERO)
		else $error("overflowed run carries color");

	// Every run covers at least one pixel
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		runs.valid |-> runs.run_len != '0)
		else $error("empty run emitted");

	// A palette write never starts a run
	a_palwr_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		byte_xfer && bytes.cmd == CMD_PAL_WR |=> !v_s1)
		else $error("palette write produced a run");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import prd_pkg::*;

	localparam int CLK_HALF       = 2;
	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = 6;
	localparam int QUIET_LIMIT    = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int MAX_PIX        = 1048576;
	localparam int STALL_PERCENT  = 22;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// One run as seen on the output channel
	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [LEN_W-1:0]  len;
		logic [CHAN_W-1:0] c0;
		logic [CHAN_W-1:0] c1;
		logic [CHAN_W-1:0] c2;
		logic [CHAN_W-1:0] c3;
		logic              err;
	} run_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	prd_byte_if bytes_if ();
	prd_run_if  runs_if ();

	palette_rle_sprite_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bytes     (bytes_if),
		.runs      (runs_if)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Decoder state as predicted from the accepted bytes
	logic [COLOR_W-1:0] pal_mem [256];
	bit                 pal_loaded_map [256];
	logic [7:0]         pal_loaded [$];
	phase_t             ph = PH_COUNT;
	int                 run_left = 0;
	logic [7:0]         run_a = 8'd0;
	int                 cur_pos = 0;

	// Register copies, reset values
	logic [1:0]      cfg_mode  = MODE_BGRA;
	logic [7:0]      cfg_tr    = CHAN_ZERO;
	logic [7:0]      cfg_tg    = CHAN_ZERO;
	logic [7:0]      cfg_tb    = CHAN_ZERO;
	logic [7:0]      cfg_thr   = 8'd1;
	logic [FP_W-1:0] cfg_frame = '0;

	run_res_t run_expect_q [$];

	bit idle_on = 1'b1;
	int stall_left = 0;
	int n_bytes = 0;
	int n_runs = 0;
	int n_ovf = 0;
	int n_fail = 0;
	int n_reported = 0;

	function automatic int frame_cap();
		return (cfg_frame > MAX_PIX) ? MAX_PIX : int'(cfg_frame);
	endfunction

	function automatic logic [7:0] mix(input logic [7:0] p, input logic [7:0] t,
			input logic [7:0] a);
		int acc;
		acc = int'(p) * int'(a) + int'(t) * (255 - int'(a));
		return 8'(acc / 255);
	endfunction

	// Channel order per mode; a suppressed run carries zero channels
	function automatic run_res_t pack_run(input int pos, input int len, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic [7:0] a, input bit err);
		run_res_t res;
		res = '0;
		res.pos = POS_W'(pos);
		res.len = LEN_W'(len);
		res.err = err;
		if (err) begin
			return res;
		end
		res.c1 = g;
		if (cfg_mode == MODE_RGB) begin
			res.c0 = r;
			res.c2 = b;
		end else if (cfg_mode == MODE_RGBA) begin
			res.c0 = r;
			res.c2 = b;
			res.c3 = a;
		end else begin
			res.c0 = b;
			res.c2 = r;
			res.c3 = a;
		end
		return res;
	endfunction

	// Run at the current position, or an overflow error that leaves it in place
	function automatic bit place_run(input int len, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a, output run_res_t res);
		res = '0;
		if (len == 0) begin
			return 1'b0;
		end
		if (cur_pos + len > frame_cap()) begin
			res = pack_run(cur_pos, len, CHAN_ZERO, CHAN_ZERO, CHAN_ZERO, CHAN_ZERO, 1'b1);
			return 1'b1;
		end
		res = pack_run(cur_pos, len, r, g, b, a, 1'b0);
		cur_pos += len;
		return 1'b1;
	endfunction

	// Advance the predicted decoder by one byte; returns 1 when a run is due
	function automatic bit decode_byte(input logic [1:0] cmd, input logic [7:0] idx,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
			input logic [7:0] data, output run_res_t res);
		logic [COLOR_W-1:0] col;
		logic [7:0] r, g, b;
		bit hit;
		res = '0;
		case (cmd)
			CMD_PAL_WR: begin
				if (!pal_loaded_map[idx]) begin
					pal_loaded_map[idx] = 1'b1;
					pal_loaded = {pal_loaded, idx};
				end
				pal_mem[idx] = {red, green, blue};
				return 1'b0;
			end
			CMD_FRAME: begin
				ph = PH_COUNT;
				run_left = 0;
				run_a = 8'd0;
				cur_pos = 0;
				if (frame_cap() == 0) begin
					return 1'b0;
				end
				res = pack_run(0, frame_cap(), cfg_tr, cfg_tg, cfg_tb, CHAN_ZERO, 1'b0);
				return 1'b1;
			end
			CMD_DATA: begin
			end
			default: begin
				return 1'b0;
			end
		endcase
		case (ph)
			PH_COUNT: begin
				run_left = int'(data);
				ph = PH_ALPHA;
				return 1'b0;
			end
			PH_ALPHA: begin
				run_a = data;
				if (data == CHAN_ZERO) begin
					ph = PH_COUNT;
					return place_run(run_left, cfg_tr, cfg_tg, cfg_tb, CHAN_ZERO, res);
				end
				ph = (run_left == 0) ? PH_COUNT : PH_INDEX;
				return 1'b0;
			end
			default: begin
				col = pal_mem[data];
				r = col[23:16];
				g = col[15:8];
				b = col[7:0];
				if (cfg_mode == MODE_RGB) begin
					if (run_a < cfg_thr) begin
						r = cfg_tr;
						g = cfg_tg;
						b = cfg_tb;
					end else begin
						r = mix(r, cfg_tr, run_a);
						g = mix(g, cfg_tg, run_a);
						b = mix(b, cfg_tb, run_a);
					end
				end
				hit = place_run(1, r, g, b, run_a, res);
				if (run_left > 0) run_left--;
				if (run_left == 0) ph = PH_COUNT;
				return hit;
			end
		endcase
	endfunction

	function automatic logic [7:0] any_loaded_index();
		return pal_loaded[$urandom_range(pal_loaded.size() - 1)];
	endfunction

	task automatic flag_failure(input string what);
		if (n_reported < MAX_REPORTS) begin
			$display("[%0t] %s", $realtime, what);
			n_reported++;
		end
		n_fail++;
	endtask

	// Result side: random stall bursts while idling is on
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			runs_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(99) < 8) begin
			stall_left <= $urandom_range(0, 4);
			runs_if.ready <= 1'b0;
		end else begin
			runs_if.ready <= 1'b1;
		end
	end

	// Compare every run transfer with the oldest prediction
	always @(posedge clk) begin : run_check
		run_res_t got, want;
		if (runs_if.valid && runs_if.ready) begin
			got.pos = runs_if.pixel_pos;
			got.len = runs_if.run_len;
			got.c0  = runs_if.chan0;
			got.c1  = runs_if.chan1;
			got.c2  = runs_if.chan2;
			got.c3  = runs_if.chan3;
			got.err = runs_if.overflow_error;
			n_runs++;
			if (got.err === 1'b1) n_ovf++;
			if (run_expect_q.size() == 0) begin
				flag_failure($sformatf("unexpected run pos=%0d len=%0d", got.pos, got.len));
			end else begin
				want = run_expect_q.pop_front();
				if (got.pos !== want.pos || got.len !== want.len || got.c0 !== want.c0 ||
						got.c1 !== want.c1 || got.c2 !== want.c2 || got.c3 !== want.c3 ||
						got.err !== want.err) begin
					flag_failure($sformatf({"run mismatch: expected pos=%0d len=%0d ",
						"ch=%h/%h/%h/%h err=%b, got pos=%0d len=%0d ch=%h/%h/%h/%h err=%b"},
						want.pos, want.len, want.c0, want.c1, want.c2, want.c3, want.err,
						got.pos, got.len, got.c0, got.c1, got.c2, got.c3, got.err));
				end
			end
		end
	end

	// Ends the run when no transfer happens for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((bytes_if.valid && bytes_if.ready) || (runs_if.valid && runs_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no transfer for %0d cycles, %0d runs still due", QUIET_LIMIT,
			run_expect_q.size());
		$display("TB_ERROR");
		$finish;
	end

	// One byte transfer, with an optional gap in front
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] idx,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
			input logic [7:0] data);
		run_res_t res;
		if (idle_on && $urandom_range(99) < STALL_PERCENT) begin
			bytes_if.valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		bytes_if.valid     <= 1'b1;
		bytes_if.cmd       <= cmd;
		bytes_if.pal_index <= idx;
		bytes_if.pal_red   <= red;
		bytes_if.pal_green <= green;
		bytes_if.pal_blue  <= blue;
		bytes_if.data_byte <= data;
		do @(posedge clk); while (bytes_if.ready !== 1'b1);
		if (cmd != CMD_UNUSED) n_bytes++;
		if (decode_byte(cmd, idx, red, green, blue, data, res))
			run_expect_q = {run_expect_q, res};
	endtask

	// Never lets an index byte point at an entry that was not loaded
	task automatic send_data(input logic [7:0] value);
		logic [7:0] b;
		b = value;
		if (ph == PH_INDEX && !pal_loaded_map[b]) b = any_loaded_index();
		send_item(CMD_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), b);
	endtask

	task automatic send_pal(input logic [7:0] idx, input logic [7:0] red,
			input logic [7:0] green, input logic [7:0] blue);
		send_item(CMD_PAL_WR, idx, red, green, blue, 8'($urandom));
	endtask

	task automatic send_frame();
		send_item(CMD_FRAME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	// Hold off the sender until every due run has come out and the pipe is empty
	task automatic settle();
		bytes_if.valid <= 1'b0;
		while (run_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [1:0] mode, input logic [7:0] tr,
			input logic [7:0] tg, input logic [7:0] tb, input logic [7:0] thr,
			input logic [FP_W-1:0] fp);
		settle();
		put_reg(CFG_OUT_MODE, CFG_DATA_W'(mode));
		put_reg(CFG_TRANS_RED, CFG_DATA_W'(tr));
		put_reg(CFG_TRANS_GREEN, CFG_DATA_W'(tg));
		put_reg(CFG_TRANS_BLUE, CFG_DATA_W'(tb));
		put_reg(CFG_ALPHA_THRESH, CFG_DATA_W'(thr));
		put_reg(CFG_FRAME_PIXELS, CFG_DATA_W'(fp));
		cfg_wr_en <= 1'b0;
		cfg_mode  = mode;
		cfg_tr    = tr;
		cfg_tg    = tg;
		cfg_tb    = tb;
		cfg_thr   = thr;
		cfg_frame = fp;
	endtask

	// Count, alpha and the pixel indices, resynced to a count byte first
	task automatic send_random_run();
		int cnt, pick;
		logic [7:0] alpha;
		while (ph != PH_COUNT) send_data(8'($urandom));
		pick = $urandom_range(99);
		if (pick < 8) cnt = 0;
		else if (pick < 12) cnt = $urandom_range(100, 255);
		else cnt = $urandom_range(1, 12);
		pick = $urandom_range(99);
		if (pick < 30) alpha = CHAN_ZERO;
		else if (pick < 40) alpha = CHAN_MAX;
		else if (pick < 45) alpha = 8'd1;
		else alpha = 8'($urandom_range(1, 255));
		send_data(8'(cnt));
		send_data(alpha);
		if (alpha != CHAN_ZERO) begin
			for (int i = 0; i < cnt; i++) begin
				if ($urandom_range(99) < 3)
					send_pal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				send_data(any_loaded_index());
			end
		end
	endtask

	// Defaults: BGRA and an empty frame, so data before any frame start overflows
	task automatic test_after_reset();
		send_pal(8'h00, CHAN_MAX, CHAN_ZERO, 8'h80);
		send_data(8'd2);
		send_data(CHAN_ZERO);
		send_frame();
		send_data(8'd1);
		send_data(8'd200);
		send_data(8'h00);
	endtask

	task automatic test_special_cases();
		load_config(MODE_RGB, 8'h10, 8'h80, CHAN_MAX, 8'd128, FP_W'(40));
		send_pal(8'hFF, CHAN_ZERO, CHAN_ZERO, CHAN_ZERO);
		send_pal(8'h5A, 8'($urandom), 8'($urandom), 8'($urandom));
		send_frame();
		// transparent run
		send_data(8'd3);
		send_data(CHAN_ZERO);
		// opaque pixels
		send_data(8'd2);
		send_data(CHAN_MAX);
		send_data(8'h00);
		send_data(8'hFF);
		// one below the threshold, one right at it
		send_data(8'd1);
		send_data(8'd127);
		send_data(8'h5A);
		send_data(8'd1);
		send_data(8'd128);
		send_data(8'h5A);
		// empty runs of both kinds
		send_data(8'd0);
		send_data(CHAN_ZERO);
		send_data(8'd0);
		send_data(8'd9);
		send_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// past the frame end
		send_data(8'd255);
		send_data(CHAN_ZERO);
	endtask

	task automatic test_frame_limits();
		// frame filled exactly, then one pixel too many
		load_config(MODE_RGBA, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX, FP_W'(3));
		send_frame();
		send_data(8'd3);
		send_data(CHAN_ZERO);
		send_data(8'd1);
		send_data(8'd77);
		send_data(8'h00);
		load_config(MODE_BGRA, 8'h12, 8'h34, 8'h56, 8'd0, FP_W'(MAX_PIX));
		send_frame();
		// oversized frame size is capped
		load_config(MODE_SPARE, 8'hA5, 8'h5A, 8'hC3, 8'd1, '1);
		send_frame();
		send_data(8'd255);
		send_data(CHAN_ZERO);
		load_config(MODE_RGB, CHAN_ZERO, CHAN_ZERO, CHAN_ZERO, 8'd1, '0);
		send_frame();
	endtask

	// Mostly well-formed runs, with palette writes, frame restarts and noise mixed in
	task automatic test_random_streams();
		logic [1:0] mode_seq [8];
		logic [7:0] tr, tg, tb, thr;
		logic [FP_W-1:0] fp;
		int stop_at, pick;
		mode_seq = '{MODE_RGB, MODE_RGBA, MODE_BGRA, MODE_SPARE,
			MODE_RGB, MODE_RGB, MODE_BGRA, MODE_RGBA};
		for (int k = 0; k < 8; k++) begin
			tr = 8'($urandom);
			tg = 8'($urandom);
			tb = 8'($urandom);
			thr = 8'($urandom_range(1, 254));
			fp = FP_W'($urandom_range(40, 700));
			if (k == 0) begin
				{tr, tg, tb, thr} = {CHAN_ZERO, CHAN_ZERO, CHAN_ZERO, CHAN_ZERO};
			end else if (k == 4) begin
				{tr, tg, tb, thr} = {CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX};
			end else if (k == 5) begin
				fp = FP_W'(MAX_PIX);
			end else if (k == 6) begin
				fp = '1;
			end
			load_config(mode_seq[k], tr, tg, tb, thr, fp);
			// one phase runs at full rate on both sides
			idle_on = (k != 3);
			send_frame();
			stop_at = n_bytes + 145;
			while (n_bytes < stop_at) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					send_random_run();
				end else if (pick < 80) begin
					send_pal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				end else if (pick < 85) begin
					send_frame();
				end else if (pick < 88) begin
					send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom));
				end else if (pick < 94) begin
					send_data(8'($urandom));
				end else begin
					// run cut short by a new frame
					send_data(8'($urandom_range(2, 20)));
					send_data(8'($urandom_range(1, 255)));
					repeat ($urandom_range(0, 1)) send_data(any_loaded_index());
					send_frame();
				end
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = CFG_OUT_MODE;
		cfg_data           = '0;
		bytes_if.valid     = 1'b0;
		bytes_if.cmd       = CMD_PAL_WR;
		bytes_if.pal_index = '0;
		bytes_if.pal_red   = '0;
		bytes_if.pal_green = '0;
		bytes_if.pal_blue  = '0;
		bytes_if.data_byte = '0;
		runs_if.ready      = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_special_cases();
		test_frame_limits();
		test_random_streams();
		settle();

		$display("Decoded %0d bytes into %0d checked runs, %0d of them overflow errors,",
			n_bytes, n_runs, n_ovf);
		$display("across all output modes, thresholds 0 to 255 and empty to oversized frames.");
		if (n_fail == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d failures", n_fail);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
